[hw/rtl/wbdts_pkg.sv]
package wbdts_pkg;

	localparam int TableDepth   = 64;
	localparam int ResultLimit  = 64;
	localparam logic [31:0] HighMaxAgeRst = 32'(5 * 1000);
	localparam logic [31:0] LowMaxAgeRst  = 32'(300 * 1000);

	typedef enum logic [2:0] {
		OP_MARK      = 3'd0,
		OP_TICK      = 3'd1,
		OP_COMPL     = 3'd2,
		OP_FLUSH_ALL = 3'd3,
		OP_FLUSH_ONE = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		K_WRITE  = 2'd0,
		K_DIRECT = 2'd1,
		K_ACK    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		S_DONE        = 2'd0,
		S_NOT_PENDING = 2'd1,
		S_BUSY        = 2'd2,
		S_FAILED      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		E_FREE     = 2'd0,
		E_DIRTY    = 2'd1,
		E_FLUSHING = 2'd2
	} estate_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_RD,
		F_EV,
		F_FIN
	} fsm_t;

	localparam logic REG_HIGH_MAX_AGE = 1'b0;
	localparam logic REG_LOW_MAX_AGE  = 1'b1;

	typedef struct packed {
		estate_t st;
		logic    rem;
	} ent_st_t;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] tm;
		logic        prio;
	} ent_rec_t;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  slot;
		logic [63:0] key;
		status_t     status;
		logic        last;
	} res_t;

endpackage

[hw/rtl/writeback_dirty_table_scheduler.sv]
// Channel  | Handshake                | Payload
// input    | in_valid / in_ready      | op, key, prio, now_ms, slot, outcome
// result   | out_valid / out_ready    | kind, out_slot, out_key, status, last
// config   | cfg_we (no wait)         | cfg_idx, cfg_wdata
//
// Mark, tick, flush-all and flush-one items scan every slot, each slot in two steps (memory
// read, then evaluate); a completion reads and evaluates only its own slot, and one whose
// slot lies past the table goes straight to its result.
// Reset clears the per-slot valid bits at once, so every slot reads as free; no clearing pass.
// A stalled result channel holds the scan at the next slot that has a write to issue.
module writeback_dirty_table_scheduler #(
	parameter int TABLE_DEPTH = wbdts_pkg::TableDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           op,
	input  logic [63:0]          key,
	input  logic                 prio,
	input  logic [31:0]          now_ms,
	input  logic [5:0]           slot,
	input  logic [1:0]           outcome,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wbdts_pkg::kind_t     kind,
	output logic [5:0]           out_slot,
	output logic [63:0]          out_key,
	output wbdts_pkg::status_t   status,
	output logic                 last,
	input  logic                 cfg_we,
	input  logic                 cfg_idx,
	input  logic [31:0]          cfg_wdata
);
	import wbdts_pkg::*;

	localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IDXW-1:0] LastIdx = IDXW'(TABLE_DEPTH - 1);

	// Configuration registers.
	logic [31:0] high_max_age_q, low_max_age_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_max_age_q <= HighMaxAgeRst;
			low_max_age_q  <= LowMaxAgeRst;
		end else if (cfg_we) begin
			if (cfg_idx == REG_HIGH_MAX_AGE) begin
				high_max_age_q <= cfg_wdata;
			end else begin
				low_max_age_q <= cfg_wdata;
			end
		end
	end

	// The table lives in two memories: the slot state with its remarked flag, and the record
	// of key, mark time and priority. A valid bit per slot stands for the reset value.
	ent_st_t  st_mem  [TABLE_DEPTH];
	ent_rec_t rec_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] vld_q;

	fsm_t fsm_q, fsm_d;

	// Item held for the whole of its processing.
	op_t         op_q;
	logic [63:0] key_q;
	logic        prio_q;
	logic [31:0] now_q;
	logic [5:0]  slot_q;
	logic [1:0]  outcome_q;
	logic        slot_ok_q;

	logic [IDXW-1:0] idx_q;

	// Memory ports.
	logic            rd_en;
	ent_st_t         st_raw_s1;
	ent_rec_t        rec_s1;
	logic            vld_s1;
	ent_st_t         st_s1;
	logic            st_we, rec_we;
	logic [IDXW-1:0] wa;
	ent_st_t         st_wd;
	ent_rec_t        rec_wd;

	// What the scan found.
	logic            found_q, free_q, busy_q;
	logic [IDXW-1:0] f_slot_q, free_slot_q;
	estate_t         f_state_q;
	logic            f_rem_q, f_prio_q;
	logic [31:0]     f_time_q;
	logic [63:0]     f_key_q;
	logic [6:0]      n_q;

	// Held result of a tick or flush-all: it is sent only once it is known whether it is last.
	logic pend_v_q;
	res_t pend_q;

	// Output register.
	logic out_v_q;
	res_t out_q;
	logic out_free;

	// Controls from the sequencer.
	logic accept, cap_ent, cap_free, busy_set, n_inc, idx_inc, out_load, pend_load;
	res_t out_d, pend_d;
	logic [31:0] age, cap;
	logic due;

	assign accept   = in_valid && in_ready;
	assign in_ready = (fsm_q == F_IDLE);
	assign out_free = !out_v_q || out_ready;

	assign out_valid = out_v_q;
	assign kind      = out_q.kind;
	assign out_slot  = out_q.slot;
	assign out_key   = out_q.key;
	assign status    = out_q.status;
	assign last      = out_q.last;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			st_raw_s1 <= st_mem[idx_q];
			rec_s1    <= rec_mem[idx_q];
		end
		if (st_we) begin
			st_mem[wa] <= st_wd;
		end
		if (rec_we) begin
			rec_mem[wa] <= rec_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (rd_en) begin
				vld_s1 <= vld_q[idx_q];
			end
			if (st_we) begin
				vld_q[wa] <= 1'b1;
			end
		end
	end

	// A slot never written reads as free with the remarked flag clear.
	assign st_s1 = vld_s1 ? st_raw_s1 : ent_st_t'{st: E_FREE, rem: 1'b0};

	assign age = now_q - rec_s1.tm;
	assign cap = rec_s1.prio ? high_max_age_q : low_max_age_q;
	assign due = (st_s1.st == E_DIRTY) && (n_q < 7'(ResultLimit))
		&& ((op_q == OP_FLUSH_ALL) || (age >= cap));

	always_comb begin
		fsm_d     = fsm_q;
		rd_en     = 1'b0;
		st_we     = 1'b0;
		rec_we    = 1'b0;
		wa        = idx_q;
		st_wd     = '{st: E_FREE, rem: 1'b0};
		rec_wd    = '0;
		cap_ent   = 1'b0;
		cap_free  = 1'b0;
		busy_set  = 1'b0;
		n_inc     = 1'b0;
		idx_inc   = 1'b0;
		out_load  = 1'b0;
		out_d     = '0;
		pend_load = 1'b0;
		pend_d    = '0;
		case (fsm_q)
			F_IDLE: begin
				if (accept) begin
					case (op_t'(op))
						OP_MARK, OP_TICK, OP_FLUSH_ALL, OP_FLUSH_ONE: fsm_d = F_RD;
						OP_COMPL: fsm_d = (32'(slot) < TABLE_DEPTH) ? F_RD : F_FIN;
						default: fsm_d = F_FIN;
					endcase
				end
			end
			F_RD: begin
				rd_en = 1'b1;
				fsm_d = F_EV;
			end
			F_EV: begin
				case (op_q)
					OP_COMPL: begin
						cap_ent = 1'b1;
						fsm_d   = F_FIN;
					end
					OP_MARK, OP_FLUSH_ONE: begin
						if (st_s1.st != E_FREE && rec_s1.key == key_q && !found_q) begin
							cap_ent = 1'b1;
						end
						if (st_s1.st == E_FREE && !free_q) begin
							cap_free = 1'b1;
						end
						idx_inc = 1'b1;
					end
					default: begin
						if (st_s1.st == E_FLUSHING) begin
							busy_set = 1'b1;
						end
						if (!due) begin
							idx_inc = 1'b1;
						end else if (!pend_v_q || out_free) begin
							st_we     = 1'b1;
							st_wd     = '{st: E_FLUSHING, rem: 1'b0};
							out_load  = pend_v_q;
							out_d     = pend_q;
							pend_load = 1'b1;
							pend_d    = '{kind: K_WRITE, slot: 6'(idx_q), key: rec_s1.key,
								status: S_DONE, last: 1'b0};
							n_inc     = 1'b1;
							idx_inc   = 1'b1;
						end
					end
				endcase
				if (idx_inc) begin
					fsm_d = (idx_q == LastIdx) ? F_FIN : F_RD;
				end
			end
			F_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					fsm_d    = F_IDLE;
					case (op_q)
						OP_MARK: begin
							if (found_q) begin
								// Priority only rises; a slot in flight gets remarked.
								st_we  = 1'b1;
								rec_we = 1'b1;
								wa     = f_slot_q;
								st_wd  = '{st: f_state_q,
									rem: (f_state_q == E_FLUSHING) ? 1'b1 : f_rem_q};
								rec_wd = '{key: key_q, tm: f_time_q, prio: f_prio_q | prio_q};
								out_d  = '{kind: K_ACK, slot: 6'(f_slot_q), key: key_q,
									status: (f_state_q == E_FLUSHING) ? S_BUSY : S_DONE,
									last: 1'b1};
							end else if (free_q) begin
								st_we  = 1'b1;
								rec_we = 1'b1;
								wa     = free_slot_q;
								st_wd  = '{st: E_DIRTY, rem: 1'b0};
								rec_wd = '{key: key_q, tm: now_q, prio: prio_q};
								out_d  = '{kind: K_ACK, slot: 6'(free_slot_q), key: key_q,
									status: S_DONE, last: 1'b1};
							end else begin
								out_d = '{kind: K_DIRECT, slot: 6'd0, key: key_q,
									status: S_DONE, last: 1'b1};
							end
						end
						OP_FLUSH_ONE: begin
							if (!found_q) begin
								out_d = '{kind: K_ACK, slot: 6'd0, key: key_q,
									status: S_NOT_PENDING, last: 1'b1};
							end else if (f_state_q == E_DIRTY) begin
								st_we = 1'b1;
								wa    = f_slot_q;
								st_wd = '{st: E_FLUSHING, rem: 1'b0};
								out_d = '{kind: K_WRITE, slot: 6'(f_slot_q), key: key_q,
									status: S_DONE, last: 1'b1};
							end else begin
								out_d = '{kind: K_ACK, slot: 6'(f_slot_q), key: key_q,
									status: S_BUSY, last: 1'b1};
							end
						end
						OP_TICK, OP_FLUSH_ALL: begin
							if (pend_v_q) begin
								out_d      = pend_q;
								out_d.last = 1'b1;
							end else begin
								out_d = '{kind: K_ACK, slot: 6'd0, key: 64'd0,
									status: (op_q == OP_TICK) ? S_NOT_PENDING
										: (busy_q ? S_BUSY : S_DONE),
									last: 1'b1};
							end
						end
						OP_COMPL: begin
							if (!slot_ok_q || f_state_q != E_FLUSHING) begin
								out_d = '{kind: K_ACK, slot: slot_q, key: 64'd0,
									status: S_NOT_PENDING, last: 1'b1};
							end else begin
								// Outcomes from write-failed upward count as failures.
								st_we = 1'b1;
								wa    = f_slot_q;
								st_wd = '{st: (f_rem_q || outcome_q[1]) ? E_DIRTY : E_FREE,
									rem: 1'b0};
								out_d = '{kind: K_ACK, slot: slot_q, key: f_key_q,
									status: outcome_q[1] ? S_FAILED : S_DONE, last: 1'b1};
							end
						end
						default: begin
							out_d = '{kind: K_ACK, slot: 6'd0, key: 64'd0,
								status: S_NOT_PENDING, last: 1'b1};
						end
					endcase
				end
			end
			default: fsm_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= F_IDLE;
		end else begin
			fsm_q <= fsm_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op_t'(op);
			key_q     <= key;
			prio_q    <= prio;
			now_q     <= now_ms;
			slot_q    <= slot;
			outcome_q <= outcome;
			slot_ok_q <= (32'(slot) < TABLE_DEPTH);
		end
		if (cap_ent) begin
			f_slot_q  <= idx_q;
			f_state_q <= st_s1.st;
			f_rem_q   <= st_s1.rem;
			f_prio_q  <= rec_s1.prio;
			f_time_q  <= rec_s1.tm;
			f_key_q   <= rec_s1.key;
		end
		if (cap_free) begin
			free_slot_q <= idx_q;
		end
		if (pend_load) begin
			pend_q <= pend_d;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			found_q  <= 1'b0;
			free_q   <= 1'b0;
			busy_q   <= 1'b0;
			n_q      <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (accept) begin
				idx_q    <= (op_t'(op) == OP_COMPL) ? IDXW'(slot) : '0;
				found_q  <= 1'b0;
				free_q   <= 1'b0;
				busy_q   <= 1'b0;
				n_q      <= '0;
				pend_v_q <= 1'b0;
			end else begin
				if (idx_inc && idx_q != LastIdx) begin
					idx_q <= idx_q + 1'b1;
				end
				if (cap_ent && op_q != OP_COMPL) begin
					found_q <= 1'b1;
				end
				if (cap_free) begin
					free_q <= 1'b1;
				end
				if (busy_set) begin
					busy_q <= 1'b1;
				end
				if (n_inc) begin
					n_q <= n_q + 7'd1;
				end
				if (pend_load) begin
					pend_v_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/wbdts_checker.sv]
module wbdts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [5:0]  out_slot,
	input logic [63:0] out_key,
	input logic [1:0]  status,
	input logic        last
);

	// A result waiting for the consumer keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(kind)
			&& $stable(out_slot) && $stable(status) && $stable(last))
		else $error("result changed while stalled");

	// The block works on one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	// A transfer that is not the last happens while the item is still being worked on.
	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |-> !in_ready)
		else $error("block idle before the final result");

endmodule

bind writeback_dirty_table_scheduler wbdts_checker u_wbdts_checker (.*);

[tb/tb_top.sv]
module tb_top;
	import wbdts_pkg::*;

	// Codes that the package does not name: ops past flush-one, and the write outcomes.
	localparam logic [2:0] OpFirstUnused = 3'd5;
	localparam logic [2:0] OpLastUnused  = 3'd7;
	localparam logic [1:0] OutPersisted  = 2'd0;
	localparam logic [1:0] OutDropped    = 2'd1;
	localparam logic [1:0] OutFailed     = 2'd2;
	localparam logic [1:0] OutUnknown    = 2'd3;
	localparam int CycleLimit = 1000000;

	// Dirty-table predictor and the queue of results still owed by the block.
	class writeback_table;
		estate_t     ent_state [TableDepth];
		logic [63:0] ent_key   [TableDepth];
		logic [31:0] ent_time  [TableDepth];
		logic        ent_prio  [TableDepth];
		logic        ent_rem   [TableDepth];
		logic [31:0] high_age;
		logic [31:0] low_age;
		res_t        owed[$];
		int          errors;
		int          checked;
		int          writes;

		function void clear();
			foreach (ent_state[i]) begin
				ent_state[i] = E_FREE;
				ent_key[i] = '0;
				ent_time[i] = '0;
				ent_prio[i] = 1'b0;
				ent_rem[i] = 1'b0;
			end
			high_age = HighMaxAgeRst;
			low_age = LowMaxAgeRst;
		endfunction

		function void set_reg(logic idx, logic [31:0] v);
			if (idx == REG_HIGH_MAX_AGE)
				high_age = v;
			else
				low_age = v;
		endfunction

		function void owe(kind_t k, logic [5:0] s, logic [63:0] key, status_t st);
			res_t r;
			r.kind = k;
			r.slot = s;
			r.key = key;
			r.status = st;
			r.last = 1'b0;
			owed.push_back(r);
		endfunction

		function int find_key(logic [63:0] key);
			for (int i = 0; i < TableDepth; i++)
				if (ent_state[i] != E_FREE && ent_key[i] == key)
					return i;
			return -1;
		endfunction

		function int find_free();
			for (int i = 0; i < TableDepth; i++)
				if (ent_state[i] == E_FREE)
					return i;
			return -1;
		endfunction

		function void start_write(int i);
			ent_state[i] = E_FLUSHING;
			ent_rem[i] = 1'b0;
			writes++;
			owe(K_WRITE, 6'(i), ent_key[i], S_DONE);
		endfunction

		// Works out the results of one accepted input transfer.
		function void note_item(logic [2:0] op, logic [63:0] key, logic prio,
				logic [31:0] now, logic [5:0] s, logic [1:0] outcome);
			int idx;
			int n;
			logic busy;
			logic failed;
			logic [31:0] cap;
			res_t r;
			n = 0;
			busy = 1'b0;
			case (op)
				OP_MARK: begin
					idx = find_key(key);
					if (idx < 0)
						idx = find_free();
					if (idx < 0) begin
						owe(K_DIRECT, '0, key, S_DONE);
					end else begin
						if (ent_state[idx] == E_FREE) begin
							ent_key[idx] = key;
							ent_time[idx] = now;
							ent_prio[idx] = prio;
							ent_state[idx] = E_DIRTY;
							ent_rem[idx] = 1'b0;
						end else begin
							ent_prio[idx] = ent_prio[idx] | prio;
							if (ent_state[idx] == E_FLUSHING)
								ent_rem[idx] = 1'b1;
						end
						owe(K_ACK, 6'(idx), key,
							ent_state[idx] == E_FLUSHING ? S_BUSY : S_DONE);
					end
				end
				OP_TICK, OP_FLUSH_ALL: begin
					for (int i = 0; i < TableDepth; i++) begin
						if (ent_state[i] == E_FLUSHING)
							busy = 1'b1;
						if (ent_state[i] == E_DIRTY && n < ResultLimit) begin
							cap = ent_prio[i] ? high_age : low_age;
							if (op == OP_FLUSH_ALL || now - ent_time[i] >= cap) begin
								start_write(i);
								n++;
							end
						end
					end
					if (n == 0)
						owe(K_ACK, '0, '0, op == OP_TICK ? S_NOT_PENDING :
							(busy ? S_BUSY : S_DONE));
				end
				OP_COMPL: begin
					if (ent_state[s] != E_FLUSHING) begin
						owe(K_ACK, s, '0, S_NOT_PENDING);
					end else begin
						failed = outcome >= OutFailed;
						if (ent_rem[s]) begin
							ent_state[s] = E_DIRTY;
							ent_rem[s] = 1'b0;
						end else begin
							ent_state[s] = failed ? E_DIRTY : E_FREE;
						end
						owe(K_ACK, s, ent_key[s], failed ? S_FAILED : S_DONE);
					end
				end
				OP_FLUSH_ONE: begin
					idx = find_key(key);
					if (idx < 0)
						owe(K_ACK, '0, key, S_NOT_PENDING);
					else if (ent_state[idx] == E_DIRTY)
						start_write(idx);
					else
						owe(K_ACK, 6'(idx), key, S_BUSY);
				end
				default: begin
					owe(K_ACK, '0, '0, S_NOT_PENDING);
				end
			endcase
			r = owed.pop_back();
			r.last = 1'b1;
			owed.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t e;
			checked++;
			if (owed.size() == 0) begin
				$error("unexpected result: kind %0d slot %0d key %h", got.kind, got.slot,
					got.key);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (got.kind !== e.kind) begin
				$error("kind: expected %0d, actual %0d", e.kind, got.kind);
				errors++;
			end
			if (got.slot !== e.slot) begin
				$error("out_slot: expected %0d, actual %0d", e.slot, got.slot);
				errors++;
			end
			if (got.key !== e.key) begin
				$error("out_key: expected %h, actual %h", e.key, got.key);
				errors++;
			end
			if (got.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, got.status);
				errors++;
			end
			if (got.last !== e.last) begin
				$error("last: expected %0d, actual %0d", e.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  op;
	logic [63:0] key;
	logic        prio;
	logic [31:0] now_ms;
	logic [5:0]  slot;
	logic [1:0]  outcome;
	logic        out_valid;
	logic        out_ready;
	kind_t       kind;
	logic [5:0]  out_slot;
	logic [63:0] out_key;
	status_t     status;
	logic        last;
	logic        cfg_we;
	logic        cfg_idx;
	logic [31:0] cfg_wdata;

	writeback_dirty_table_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .key(key), .prio(prio), .now_ms(now_ms), .slot(slot), .outcome(outcome),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .out_slot(out_slot), .out_key(out_key), .status(status), .last(last),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	writeback_table tbl = new();
	int unsigned send_idle;   // percentage of cycles in which the sender holds back
	int unsigned recv_stall;  // percentage of cycles in which the receiver stalls
	int unsigned cycles;
	int unsigned items;
	logic [31:0] clock_ms;    // the time that marks and ticks carry; it wraps
	logic [63:0] key_pool[24];

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// The result side: every transfer is checked against the oldest expectation, and
	// out_ready is redrawn each cycle from the current stall rate.
	always @(posedge clk) begin
		res_t got;
		if (arst_n && out_valid && out_ready) begin
			got.kind = kind;
			got.slot = out_slot;
			got.key = out_key;
			got.status = status;
			got.last = last;
			tbl.check_result(got);
		end
		out_ready <= arst_n && ($urandom_range(99) >= recv_stall);
	end

	// Watchdog: a hung block would otherwise leave the run waiting for ever.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles,
				tbl.owed.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Presents one input transfer and waits for it to be taken. Valid is left high on
	// return, so that a back-to-back item only changes the payload.
	task automatic send(logic [2:0] o, logic [63:0] k, logic p, logic [31:0] t,
			logic [5:0] s, logic [1:0] oc);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		key <= k;
		prio <= p;
		now_ms <= t;
		slot <= s;
		outcome <= oc;
		do
			@(posedge clk);
		while (!in_ready);
		tbl.note_item(o, k, p, t, s, oc);
		items++;
	endtask

	// Lets every owed result come out, plus a short margin, so that the block is idle.
	task automatic drain();
		in_valid <= 1'b0;
		while (tbl.owed.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tbl.set_reg(idx, v);
	endtask

	function automatic logic [63:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	// Picks a slot that is flushing, so that most completions settle a real write.
	function automatic logic [5:0] busy_slot();
		int cand[$];
		for (int i = 0; i < TableDepth; i++)
			if (tbl.ent_state[i] == E_FLUSHING)
				cand.push_back(i);
		if (cand.size() == 0 || $urandom_range(99) < 15)
			return 6'($urandom_range(63));
		return 6'(cand[$urandom_range(cand.size() - 1)]);
	endfunction

	// One random transfer, weighted towards marks, ticks and completions on keys that
	// repeat, so that entries go round the free, dirty and flushing states.
	task automatic random_item();
		int unsigned pick;
		logic [63:0] k;
		pick = $urandom_range(99);
		k = ($urandom_range(9) == 0) ? rand_key() : key_pool[$urandom_range(23)];
		if ($urandom_range(19) == 0)
			clock_ms = clock_ms + $urandom;
		else
			clock_ms = clock_ms + $urandom_range(3000);
		if (pick < 35)
			send(OP_MARK, k, 1'($urandom), clock_ms, 6'($urandom), 2'($urandom));
		else if (pick < 55)
			send(OP_TICK, k, 1'($urandom), clock_ms, 6'($urandom), 2'($urandom));
		else if (pick < 80)
			send(OP_COMPL, k, 1'($urandom), clock_ms, busy_slot(),
				2'($urandom_range(OutPersisted, OutUnknown)));
		else if (pick < 87)
			send(OP_FLUSH_ALL, k, 1'($urandom), clock_ms, 6'($urandom), 2'($urandom));
		else if (pick < 97)
			send(OP_FLUSH_ONE, k, 1'($urandom), clock_ms, 6'($urandom), 2'($urandom));
		else
			send(3'($urandom_range(OpFirstUnused, OpLastUnused)), k, 1'($urandom),
				clock_ms, 6'($urandom), 2'($urandom));
	endtask

	initial begin
		logic [31:0] high_set[4];
		logic [31:0] low_set[4];
		int unsigned idle_set[4];
		int unsigned stall_set[4];
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		op = OP_MARK;
		key = '0;
		prio = 1'b0;
		now_ms = '0;
		slot = '0;
		outcome = OutPersisted;
		cfg_we = 1'b0;
		cfg_idx = REG_HIGH_MAX_AGE;
		cfg_wdata = '0;
		cycles = 0;
		items = 0;
		send_idle = 0;
		recv_stall = 0;
		clock_ms = 32'd10;
		tbl.errors = 0;
		tbl.checked = 0;
		tbl.writes = 0;
		tbl.clear();
		foreach (key_pool[i])
			key_pool[i] = rand_key();
		key_pool[0] = '0;
		key_pool[1] = '1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at the reset thresholds: empty-table answers, unknown ops, the
		// extreme keys and times, a priority raise, a mark during a write, a remarked
		// completion, failed and dropped writes and the odd outcome code.
		send(OpFirstUnused, '1, 1'b1, '1, '1, OutUnknown);
		send(OpLastUnused, '0, 1'b0, '0, '0, OutPersisted);
		send(OP_TICK, '0, 1'b0, '0, '0, OutPersisted);
		send(OP_FLUSH_ALL, '0, 1'b0, '0, '0, OutPersisted);
		send(OP_FLUSH_ONE, '1, 1'b0, '0, '0, OutPersisted);
		send(OP_COMPL, '0, 1'b0, '0, 6'd63, OutFailed);
		send(OP_MARK, '0, 1'b0, '0, '0, OutPersisted);
		send(OP_MARK, '1, 1'b1, '1, '1, OutPersisted);
		send(OP_MARK, '0, 1'b1, 32'd77, '0, OutPersisted);
		// The all-ones key, marked at the top of time, is just due after the wrap.
		send(OP_TICK, '0, 1'b0, 32'd4998, '0, OutPersisted);
		send(OP_TICK, '0, 1'b0, 32'd4999, '0, OutPersisted);
		send(OP_FLUSH_ONE, '0, 1'b0, '0, '0, OutPersisted);
		send(OP_MARK, '0, 1'b0, 32'd5, '0, OutPersisted);
		send(OP_FLUSH_ONE, '0, 1'b0, '0, '0, OutPersisted);
		send(OP_COMPL, '0, 1'b0, '0, 6'd0, OutPersisted);
		send(OP_COMPL, '0, 1'b0, '0, 6'd1, OutUnknown);
		send(OP_FLUSH_ALL, '0, 1'b0, '0, '0, OutPersisted);
		send(OP_FLUSH_ALL, '0, 1'b0, '0, '0, OutPersisted);
		send(OP_COMPL, '0, 1'b0, '0, 6'd0, OutDropped);
		send(OP_COMPL, '0, 1'b0, '0, 6'd1, OutFailed);
		send(OP_COMPL, '0, 1'b0, '0, 6'd1, OutPersisted);
		send(OP_TICK, '0, 1'b0, '1, '0, OutPersisted);

		// Fill the table past its size so that marks fall back to a direct save, then
		// flush everything in one item (the full burst of writes). The random phases
		// that follow retire those writes through their completions.
		for (int i = 0; i < TableDepth + 2; i++)
			send(OP_MARK, rand_key(), 1'($urandom), clock_ms, '0, OutPersisted);
		send(OP_FLUSH_ALL, '0, 1'b0, clock_ms, '0, OutPersisted);
		drain();

		// Random phases: each one sets both thresholds (zero and all-ones among them)
		// and a different mix of sender gaps and receiver stalls.
		high_set = '{32'd0, 32'hFFFF_FFFF, 32'd2500, HighMaxAgeRst};
		low_set = '{32'hFFFF_FFFF, 32'd0, 32'd9000, LowMaxAgeRst};
		idle_set = '{0, 68, 0, 11};
		stall_set = '{0, 0, 68, 11};
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_HIGH_MAX_AGE, high_set[ph]);
			write_reg(REG_LOW_MAX_AGE, low_set[ph]);
			send_idle = idle_set[ph];
			recv_stall = stall_set[ph];
			for (int i = 0; i < 5; i++)
				random_item();
			drain();
		end

		repeat (20) @(posedge clk);
		$display("%0d input transfers, %0d results checked, %0d writes issued,",
			items, tbl.checked, tbl.writes);
		$display("over four threshold settings and four sender/receiver idling mixes");
		if (tbl.errors == 0 && tbl.owed.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/wbdts_pkg.sv
hw/rtl/writeback_dirty_table_scheduler.sv
hw/rtl/wbdts_checker.sv
tb/tb_top.sv
